// File: hw/rtl/wmhp_pkg.sv
package wmhp_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 8191;
    localparam int unsigned DEF_SSID_ELEMENT_ID = 0;

    localparam int unsigned BODY_W     = 13;
    localparam int unsigned OFFSET_W   = 13;
    localparam int unsigned ADDR_BYTES = 6;

    localparam logic [5:0] MGMT_HDR_BYTES      = 6'd24;
    localparam logic [5:0] FOUR_ADDR_HDR_BYTES = 6'd30;
    localparam logic [5:0] QOS_CTRL_BYTES      = 6'd2;

    localparam logic [3:0] FIXED_ASSOC_BYTES  = 4'd4;
    localparam logic [3:0] FIXED_BEACON_BYTES = 4'd12;

    localparam logic [1:0] TYPE_MGMT = 2'd0;
    localparam logic [1:0] TYPE_DATA = 2'd2;

    localparam logic [3:0] SUB_ASSOC_REQ = 4'd0;
    localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
    localparam logic [3:0] SUB_PROBE_RSP = 4'd5;
    localparam logic [3:0] SUB_BEACON    = 4'd8;

    // first byte position of each address field within the header
    localparam logic [4:0] ADDR_BASE [4] = '{5'd4, 5'd10, 5'd16, 5'd24};

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_ASSOC_REQ = 3'd1,
        KIND_PROBE_REQ = 3'd2,
        KIND_PROBE_RSP = 3'd3,
        KIND_BEACON    = 3'd4,
        KIND_DATA      = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        PH_ID        = 4'b0001,
        PH_SSID_LEN  = 4'b0010,
        PH_OTHER_LEN = 4'b0100,
        PH_SSID_CHAR = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          frame_kind;
        logic [15:0]         frame_control;
        logic [47:0]         dest_address;
        logic [47:0]         source_address;
        logic [47:0]         bss_address;
        logic                bss_valid;
        logic [5:0]          header_length;
        logic [BODY_W-1:0]   body_length;
        logic                ssid_found;
        logic [OFFSET_W-1:0] ssid_offset;
        logic [7:0]          ssid_length;
        logic                header_complete;
    } t_result;

    typedef struct packed {
        logic [15:0]      ctrl;
        logic [3:0][47:0] addr;
    } t_frame_view;

    typedef struct packed {
        logic       hit;
        logic [7:0] len;
    } t_ssid_view;

    function automatic t_kind kind_of(input logic [15:0] ctrl);
        t_kind k;
        k = KIND_NONE;
        if (ctrl[3:2] == TYPE_DATA) begin
            k = KIND_DATA;
        end else if (ctrl[3:2] == TYPE_MGMT) begin
            unique case (ctrl[7:4])
                SUB_ASSOC_REQ: k = KIND_ASSOC_REQ;
                SUB_PROBE_REQ: k = KIND_PROBE_REQ;
                SUB_PROBE_RSP: k = KIND_PROBE_RSP;
                SUB_BEACON:    k = KIND_BEACON;
                default:       k = KIND_NONE;
            endcase
        end
        return k;
    endfunction

    function automatic logic is_mgmt(input t_kind k);
        return (k == KIND_ASSOC_REQ) || (k == KIND_PROBE_REQ) ||
               (k == KIND_PROBE_RSP) || (k == KIND_BEACON);
    endfunction

    function automatic logic [3:0] fixed_field_bytes(input t_kind k);
        logic [3:0] n;
        n = 4'd0;
        if (k == KIND_ASSOC_REQ) begin
            n = FIXED_ASSOC_BYTES;
        end else if ((k == KIND_PROBE_RSP) || (k == KIND_BEACON)) begin
            n = FIXED_BEACON_BYTES;
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/wmhp_ifs.sv
interface wmhp_in_if;
    import wmhp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface wmhp_out_if;
    import wmhp_pkg::*;

    logic    valid;
    logic    ready;
    t_result item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: hw/rtl/wmhp_frame_track.sv
module wmhp_frame_track #(
    parameter int unsigned MAX_FRAME_BYTES = wmhp_pkg::DEF_MAX_FRAME_BYTES,
    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  wmhp_pkg::t_in_item     i_item,
    output logic [POS_W-1:0]       o_cur_pos,
    output logic                   o_in_range,
    output logic [POS_W-1:0]       o_upd_pos,
    output wmhp_pkg::t_frame_view  o_view
);
    import wmhp_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_ctrl, n_ctrl;
    logic [3:0][47:0] r_addr, n_addr;
    logic [3:0][2:0]  lane;
    logic             in_range;

    always_comb begin
        in_range = r_pos < POS_MAX;
        n_pos    = r_pos;
        n_ctrl   = r_ctrl;
        n_addr   = r_addr;
        for (int i = 0; i < 4; i++) begin
            lane[i] = 3'(r_pos - POS_W'(ADDR_BASE[i]));
        end
        if (i_step && in_range) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_ctrl[7:0] = i_item.data_byte;
            end else if (r_pos == POS_W'(1)) begin
                n_ctrl[15:8] = i_item.data_byte;
            end
            for (int i = 0; i < 4; i++) begin
                if ((r_pos >= POS_W'(ADDR_BASE[i])) &&
                    (r_pos < POS_W'(ADDR_BASE[i] + ADDR_BYTES))) begin
                    n_addr[i][{lane[i], 3'b000} +: 8] = i_item.data_byte;
                end
            end
        end
    end

    // the last byte of a frame leaves everything cleared for the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.frame_end)) begin
            r_pos  <= '0;
            r_ctrl <= '0;
            r_addr <= '0;
        end else begin
            r_pos  <= n_pos;
            r_ctrl <= n_ctrl;
            r_addr <= n_addr;
        end
    end

    assign o_cur_pos   = r_pos;
    assign o_in_range  = in_range;
    assign o_upd_pos   = n_pos;
    assign o_view.ctrl = n_ctrl;
    assign o_view.addr = n_addr;
endmodule

// File: hw/rtl/wmhp_ie_walk.sv
module wmhp_ie_walk #(
    parameter int unsigned MAX_FRAME_BYTES = wmhp_pkg::DEF_MAX_FRAME_BYTES,
    parameter int unsigned SSID_ELEMENT_ID = wmhp_pkg::DEF_SSID_ELEMENT_ID,
    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  wmhp_pkg::t_in_item    i_item,
    input  logic                  i_in_range,
    input  logic [POS_W-1:0]      i_cur_pos,
    input  logic [15:0]           i_ctrl,
    output logic [POS_W-1:0]      o_ssid_pos,
    output wmhp_pkg::t_ssid_view  o_ssid
);
    import wmhp_pkg::*;

    localparam int unsigned SUM_W = POS_W + 9;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_next, n_next;
    t_phase           r_phase, n_phase;
    logic             r_hit, n_hit;
    logic             r_active, n_active;
    logic [POS_W-1:0] r_spos, n_spos;
    logic [7:0]       r_slen, n_slen;
    logic [SUM_W-1:0] nx_sum;
    t_kind            kind;
    logic [7:0]       d;

    always_comb begin
        d        = i_item.data_byte;
        kind     = kind_of(i_ctrl);
        nx_sum   = SUM_W'(i_cur_pos) + SUM_W'(d) + SUM_W'(1);
        n_next   = r_next;
        n_phase  = r_phase;
        n_hit    = r_hit;
        n_active = r_active;
        n_spos   = r_spos;
        n_slen   = r_slen;
        if (i_step && i_in_range) begin
            if (i_cur_pos == POS_W'(1)) begin
                // first element sits right after the fixed fields
                n_next = POS_W'(MGMT_HDR_BYTES) + POS_W'(fixed_field_bytes(kind));
            end else if ((i_cur_pos >= POS_W'(2)) && r_active && is_mgmt(kind)) begin
                unique case (r_phase)
                    PH_ID: begin
                        if (i_cur_pos == r_next) begin
                            n_phase = (d == 8'(SSID_ELEMENT_ID)) ? PH_SSID_LEN : PH_OTHER_LEN;
                        end
                    end
                    PH_SSID_LEN: begin
                        if (d == 8'd0) begin
                            n_active = 1'b0;
                        end else begin
                            n_spos  = i_cur_pos + 1'b1;
                            n_slen  = d;
                            n_phase = PH_SSID_CHAR;
                        end
                    end
                    PH_OTHER_LEN: begin
                        n_next  = (nx_sum > SUM_W'(MAX_FRAME_BYTES)) ? POS_MAX
                                                                     : POS_W'(nx_sum);
                        n_phase = PH_ID;
                    end
                    PH_SSID_CHAR: begin
                        if (d != 8'd0) begin
                            n_hit = 1'b1;
                        end
                        n_active = 1'b0;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.frame_end)) begin
            r_next   <= '0;
            r_phase  <= PH_ID;
            r_hit    <= 1'b0;
            r_active <= 1'b1;
            r_spos   <= '0;
            r_slen   <= '0;
        end else begin
            r_next   <= n_next;
            r_phase  <= n_phase;
            r_hit    <= n_hit;
            r_active <= n_active;
            r_spos   <= n_spos;
            r_slen   <= n_slen;
        end
    end

    assign o_ssid_pos = n_spos;
    assign o_ssid.hit = n_hit;
    assign o_ssid.len = n_slen;
endmodule

// File: hw/rtl/wmhp_summary.sv
module wmhp_summary #(
    parameter int unsigned MAX_FRAME_BYTES = wmhp_pkg::DEF_MAX_FRAME_BYTES,
    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic [POS_W-1:0]      i_pos,
    input  wmhp_pkg::t_frame_view i_view,
    input  logic [POS_W-1:0]      i_ssid_pos,
    input  wmhp_pkg::t_ssid_view  i_ssid,
    output wmhp_pkg::t_result     o_result
);
    import wmhp_pkg::*;

    t_kind            kind;
    logic [1:0]       ds;
    logic [47:0]      da, sa, bss;
    logic             bvalid, found, complete;
    logic [5:0]       hlen;
    logic [POS_W-1:0] body;

    always_comb begin
        kind   = kind_of(i_view.ctrl);
        ds     = {i_view.ctrl[8], i_view.ctrl[9]};
        da     = '0;
        sa     = '0;
        bss    = '0;
        bvalid = 1'b0;
        hlen   = MGMT_HDR_BYTES;
        found  = 1'b0;
        if (is_mgmt(kind)) begin
            da     = i_view.addr[0];
            sa     = i_view.addr[1];
            bss    = i_view.addr[2];
            bvalid = 1'b1;
            found  = i_ssid.hit;
        end else if (kind == KIND_DATA) begin
            // ds is {tods, fromds}
            unique case (ds)
                2'b00: begin
                    da = i_view.addr[0]; sa = i_view.addr[1];
                    bss = i_view.addr[2]; bvalid = 1'b1;
                end
                2'b01: begin
                    da = i_view.addr[0]; sa = i_view.addr[2];
                    bss = i_view.addr[1]; bvalid = 1'b1;
                end
                2'b10: begin
                    da = i_view.addr[2]; sa = i_view.addr[1];
                    bss = i_view.addr[0]; bvalid = 1'b1;
                end
                default: begin
                    da = i_view.addr[2]; sa = i_view.addr[3];
                    hlen = FOUR_ADDR_HDR_BYTES;
                end
            endcase
            // subtype bit 3 marks qos data
            if (i_view.ctrl[7]) begin
                hlen = hlen + QOS_CTRL_BYTES;
            end
        end
        complete = i_pos >= POS_W'(hlen);
        body     = complete ? (i_pos - POS_W'(hlen)) : '0;

        o_result.frame_kind      = 3'(kind);
        o_result.frame_control   = i_view.ctrl;
        o_result.dest_address    = da;
        o_result.source_address  = sa;
        o_result.bss_address     = bss;
        o_result.bss_valid       = bvalid;
        o_result.header_length   = hlen;
        o_result.body_length     = BODY_W'(body);
        o_result.ssid_found      = found;
        o_result.ssid_offset     = found ? OFFSET_W'(i_ssid_pos) : '0;
        o_result.ssid_length     = found ? i_ssid.len : '0;
        o_result.header_complete = complete;
    end
endmodule

// File: hw/rtl/wifi_mac_header_parser.sv
// channel  dir  payload                                  transfer
// i_in     in   data_byte, frame_end                     valid & ready
// o_out    out  frame summary (kind, addresses, lengths,  valid & ready
//               ssid position, header_complete)
//
// one byte per cycle sustained unless a held result stalls input; each byte is held in the
// input register, and the summary of a frame is loaded into the result register at the edge
// where its last byte leaves the input register.
// reset (synchronous, active low) clears the frame state and both valid flags.
// a held result stalls input only when the next final byte must be summarised;
// other bytes keep flowing while the result waits.
module wifi_mac_header_parser #(
    parameter int unsigned MAX_FRAME_BYTES = wmhp_pkg::DEF_MAX_FRAME_BYTES,
    parameter int unsigned SSID_ELEMENT_ID = wmhp_pkg::DEF_SSID_ELEMENT_ID
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wmhp_in_if.sink           i_in,
    wmhp_out_if.source        o_out
);
    import wmhp_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic             r_out_valid;
    t_result          r_out_item;
    logic             s1_adv;
    logic [POS_W-1:0] cur_pos, upd_pos, ssid_pos;
    logic             in_range;
    t_frame_view      view;
    t_ssid_view       ssid;
    t_result          result;

    assign s1_adv     = r_s1_valid && (!r_s1_item.frame_end || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item <= i_in.item;
        end
    end

    wmhp_frame_track #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_adv),
        .i_item     (r_s1_item),
        .o_cur_pos  (cur_pos),
        .o_in_range (in_range),
        .o_upd_pos  (upd_pos),
        .o_view     (view)
    );

    wmhp_ie_walk #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .SSID_ELEMENT_ID(SSID_ELEMENT_ID)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_adv),
        .i_item     (r_s1_item),
        .i_in_range (in_range),
        .i_cur_pos  (cur_pos),
        .i_ctrl     (view.ctrl),
        .o_ssid_pos (ssid_pos),
        .o_ssid     (ssid)
    );

    wmhp_summary #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_summary (
        .i_pos      (upd_pos),
        .i_view     (view),
        .i_ssid_pos (ssid_pos),
        .i_ssid     (ssid),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_item.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_item.frame_end) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_item.frame_end |=> o_out.valid)
        else $error("final byte did not produce a summary");

    a_hlen_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.item.header_length == 6'd24) ||
                        (o_out.item.header_length == 6'd26) ||
                        (o_out.item.header_length == 6'd30) ||
                        (o_out.item.header_length == 6'd32))
        else $error("illegal header length");

    a_ssid_mgmt_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.item.ssid_found |->
            (o_out.item.frame_kind != 3'(KIND_NONE)) &&
            (o_out.item.frame_kind != 3'(KIND_DATA)))
        else $error("ssid reported for a non-management frame");

    a_short_no_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.item.header_complete |-> o_out.item.body_length == '0)
        else $error("body length on an incomplete header");
endmodule
